// ===== rtl/stf_pkg.sv =====
// Shared types and constants for the smallest-prime-factor factorizer.
package stf_pkg;
	localparam int unsigned MaxValue = 65535;
	localparam int NumW = 16;
	localparam int ExpW = 4;
	localparam int CntW = 8;
	localparam int MaxResults = 6;

	// Divider request and response
	typedef struct packed {
		logic            start;
		logic [NumW-1:0] dividend;
		logic [NumW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [NumW-1:0] quotient;
		logic [NumW-1:0] remainder;
	} div_rsp_t;
endpackage

// ===== rtl/spf_table_factorizer.sv =====
// Top level: linear-sieve table build, then factorization through a shared divider.
//
//  channel | dir | fields (tdata low bit up)                    | extra
//  s_axis  | in  | number[15:0]                                 | -
//  m_axis  | out | prime[15:0] exponent[19:16] divisor_count[27:20] | tlast = last
//
// After reset a clearing pass zeroes the table, then the sieve walks every value from 2
// up to the top value, stepping through the prime list for each one.
// No request is taken until the build is done.
// Each division runs in the shared 16-bit restoring divider. A number needs one division
// per exponent step plus one failing trial per prime, plus a table lookup and a result
// per prime. 0, 1 and out-of-range numbers skip the lookup and the divider.
// The block holds one number at a time; a stalled result holds the sequencer.
module spf_table_factorizer #(
	parameter int unsigned MAX_VALUE = stf_pkg::MaxValue
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // number[15:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // prime, exponent, divisor_count, zero pad
	output logic        m_axis_tlast    // last
);
	localparam int W = stf_pkg::NumW;
	localparam logic [W:0] Top = (MAX_VALUE > 65535) ? 17'd65535 : 17'(MAX_VALUE);
	localparam int PW = 13;  // prime list index (6542 primes below 65536)

	localparam logic [3:0] ST_CLR = 4'd0, ST_SCAN = 4'd1, ST_SCHK = 4'd2,
		ST_MARK = 4'd3, ST_MRD = 4'd4, ST_IDLE = 4'd5, ST_LOOK = 4'd6,
		ST_LWAIT = 4'd7, ST_DIV = 4'd8, ST_DWAIT = 4'd9, ST_OUT = 4'd10,
		ST_PLRD = 4'd11;

	logic [3:0]     st_q;
	logic [W-1:0]   tbl [0:65535];
	logic [W-1:0]   plist [0:8191];
	logic [W-1:0]   tbl_rd_q;
	logic [W-1:0]   pl_rd_q;
	logic [W:0]     i_q;
	logic [PW-1:0]  cnt_q;
	logic [PW-1:0]  k_q;
	logic [W-1:0]   spf_i_q;
	logic [W-1:0]   m_q;
	logic [W-1:0]   p_q;
	logic [3:0]     e_q;
	logic [7:0]     tau_q;
	logic [2:0]     n_q;
	logic [W+W:0]   prod;
	logic [W-1:0]   o_prime_q;
	logic [3:0]     o_exp_q;
	logic [7:0]     o_cnt_q;
	logic           o_last_q;
	logic           o_valid_q;
	logic           tbl_we;
	logic [W-1:0]   tbl_wa;
	logic [W-1:0]   tbl_wd;
	logic [W-1:0]   tbl_ra;
	logic [7:0]     tau_nx;
	stf_pkg::div_req_t dreq;
	stf_pkg::div_rsp_t drsp;

	stf_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign prod   = (W+W+1)'(i_q) * (W+W+1)'(pl_rd_q);
	assign tau_nx = 8'(tau_q * ({4'd0, e_q} + 8'd1));

	// Table memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (tbl_we) tbl[tbl_wa] <= tbl_wd;
		tbl_rd_q <= tbl[tbl_ra];
	end

	// Prime list memory
	always_ff @(posedge clk) begin
		if (st_q == ST_SCHK && tbl_rd_q == '0) plist[cnt_q] <= i_q[W-1:0];
		pl_rd_q <= plist[k_q];
	end

	// Table port selection
	always_comb begin
		tbl_we = 1'b0;
		tbl_wa = i_q[W-1:0];
		tbl_wd = '0;
		tbl_ra = i_q[W-1:0];
		case (st_q)
			ST_CLR: begin
				tbl_we = 1'b1;
			end
			ST_SCHK: begin
				tbl_we = (tbl_rd_q == '0);
				tbl_wd = i_q[W-1:0];
			end
			ST_MARK: begin
				tbl_we = !(pl_rd_q > spf_i_q || prod > {{W{1'b0}}, Top}) && k_q < cnt_q;
				tbl_wa = prod[W-1:0];
				tbl_wd = pl_rd_q;
			end
			ST_LOOK: tbl_ra = m_q;
			default: ;
		endcase
	end

	assign dreq.start    = (st_q == ST_DIV);
	assign dreq.dividend = m_q;
	assign dreq.divisor  = p_q;

	// Sequencer: sieve build then factor walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_CLR;
			i_q       <= '0;
			cnt_q     <= '0;
			k_q       <= '0;
			o_valid_q <= 1'b0;
		end else begin
			if (o_valid_q && m_axis_tready) o_valid_q <= 1'b0;
			case (st_q)
				ST_CLR: begin
					if (i_q == {1'b0, {W{1'b1}}}) begin
						i_q <= (W+1)'(2);
						st_q <= ST_SCAN;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (i_q > Top) st_q <= ST_IDLE;
					else st_q <= ST_SCHK;
				end
				ST_SCHK: begin
					k_q <= '0;
					if (tbl_rd_q == '0) begin
						spf_i_q <= i_q[W-1:0];
						cnt_q   <= cnt_q + 1'b1;
					end else begin
						spf_i_q <= tbl_rd_q;
					end
					st_q <= ST_MRD;
				end
				ST_MRD: st_q <= ST_MARK;
				ST_MARK: begin
					if (k_q >= cnt_q || pl_rd_q > spf_i_q ||
						prod > {{W{1'b0}}, Top}) begin
						i_q  <= i_q + 1'b1;
						st_q <= ST_SCAN;
					end else begin
						k_q  <= k_q + 1'b1;
						st_q <= ST_MRD;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						m_q   <= s_axis_tdata;
						tau_q <= 8'd1;
						n_q   <= '0;
						if (s_axis_tdata <= 16'd1 || {1'b0, s_axis_tdata} > Top) begin
							o_prime_q <= '0;
							o_exp_q   <= '0;
							o_cnt_q   <= (s_axis_tdata <= 16'd1) ? 8'd1 : 8'd0;
							o_last_q  <= 1'b1;
							o_valid_q <= 1'b1;
							st_q      <= ST_OUT;
						end else begin
							st_q <= ST_LOOK;
						end
					end
				end
				ST_LOOK: st_q <= ST_LWAIT;
				ST_LWAIT: begin
					p_q  <= (tbl_rd_q < 16'd2) ? m_q : tbl_rd_q;
					e_q  <= '0;
					st_q <= ST_DIV;
				end
				ST_DIV: st_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (drsp.done) begin
						if (drsp.remainder == '0) begin
							m_q  <= drsp.quotient;
							e_q  <= e_q + 1'b1;
							st_q <= ST_DIV;
						end else begin
							tau_q     <= tau_nx;
							o_prime_q <= p_q;
							o_exp_q   <= e_q;
							o_cnt_q   <= tau_nx;
							o_last_q  <= (m_q <= 16'd1);
							o_valid_q <= 1'b1;
							n_q       <= n_q + 1'b1;
							st_q      <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (!o_valid_q || m_axis_tready) begin
						if (o_last_q || n_q == 3'(stf_pkg::MaxResults)) st_q <= ST_PLRD;
						else st_q <= ST_LOOK;
					end
				end
				ST_PLRD: begin
					if (!o_valid_q) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (st_q == ST_IDLE);
	assign m_axis_tvalid = o_valid_q;
	assign m_axis_tdata  = {4'd0, o_cnt_q, o_exp_q, o_prime_q};
	assign m_axis_tlast  = o_last_q | (n_q == 3'(stf_pkg::MaxResults));

	property p_no_ready_busy;
		@(posedge clk) disable iff (!arst_n) s_axis_tready |-> !o_valid_q;
	endproperty
	a_no_ready_busy: assert property (p_no_ready_busy)
		else $error("accepting while result pending");

	property p_hold;
		@(posedge clk) disable iff (!arst_n)
			o_valid_q && !m_axis_tready |=> o_valid_q && $stable(o_prime_q);
	endproperty
	a_hold: assert property (p_hold) else $error("result changed under stall");

	property p_div_idle;
		@(posedge clk) disable iff (!arst_n) drsp.done |-> st_q == ST_DWAIT;
	endproperty
	a_div_idle: assert property (p_div_idle) else $error("stray divider result");
endmodule

// ===== rtl/stf_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module stf_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  stf_pkg::div_req_t req,
	output stf_pkg::div_rsp_t rsp
);
	localparam int W = stf_pkg::NumW;
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    trial;
	logic [W:0]    shifted;

	assign shifted = {rem_q, quo_q[W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	// One shift-subtract step per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == CW'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

	property p_done_after_busy;
		@(posedge clk) disable iff (!arst_n) done_q |-> $past(busy_q);
	endproperty
	a_done_after_busy: assert property (p_done_after_busy)
		else $error("divider done without busy");

	property p_no_start_busy;
		@(posedge clk) disable iff (!arst_n) busy_q && cnt_q != CW'(1) |=> busy_q || req.start;
	endproperty
	a_no_start_busy: assert property (p_no_start_busy)
		else $error("divider dropped busy early");

	property p_done_pulse;
		@(posedge clk) disable iff (!arst_n) done_q |=> !done_q;
	endproperty
	a_done_pulse: assert property (p_done_pulse)
		else $error("divider done held");
endmodule
